>>> src/tpeg_pkg.sv
// Package for the tempo pulse edge generator.
// Types, codes and constants shared by the tpeg modules other than the divider; no dependencies.
package tpeg_pkg;

  localparam int MaxEdges = 32;
  localparam int IterBudget = 4096;
  localparam int IterW = $clog2(IterBudget + 1);
  localparam int LimW = 6;

  localparam logic [LimW-1:0] LIM_CAP = LimW'(MaxEdges);
  localparam logic [LimW-1:0] LIM_ONE = LimW'(1);
  localparam logic [IterW-1:0] ITER_CAP = IterW'(IterBudget);
  localparam logic [IterW-1:0] ITER_ONE = IterW'(1);

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [1:0] REG_BEAT_PERIOD = 2'd0;
  localparam logic [1:0] REG_PULSES_PER_BEAT = 2'd1;
  localparam logic [1:0] REG_TRIGGER_LENGTH = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [63:0] origin_time;
    logic [63:0] window_start;
    logic [63:0] window_end;
    logic [5:0]  edge_limit;
  } in_item_t;

  typedef struct packed {
    logic [63:0] edge_time;
    logic        rising;
    logic        edge_valid;
    logic        last;
  } out_item_t;

  // Signed compare of two's complement times.
  function automatic logic s_less(input logic [63:0] a, input logic [63:0] b);
    s_less = $signed(a) < $signed(b);
  endfunction

endpackage

>>> src/tpeg_fifo.sv
// Two-entry queue for packed items.
// Depends on tpeg_pkg for the item types.
module tpeg_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tpeg_pkg::in_item_t  din,
  output logic                full,
  input  logic                pop,
  output tpeg_pkg::in_item_t  dout,
  output logic                empty
);
  tpeg_pkg::in_item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= din;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule

>>> src/tpeg_divider.sv
// Restoring divider: 64-bit beat period by 16-bit divider, one bit a cycle.
// Depends on tpeg_pkg only by naming convention.
module tpeg_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [63:0] quotient,
  output logic [15:0] remainder
);
  logic [6:0] count;
  logic [16:0] trial;

  assign trial = {remainder, quotient[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 7'd64;
      quotient <= dividend;
      remainder <= 16'd0;
    end else if (busy) begin
      // shift one dividend bit in, subtract when it fits
      if (!trial[16]) begin
        remainder <= trial[15:0];
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        remainder <= {remainder[14:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end
      count <= count - 7'd1;
      if (count == 7'd1) busy <= 1'b0;
    end
  end
endmodule

>>> src/tpeg_engine.sv
// Back part: walks pulse edges for one command at a time.
// Depends on tpeg_pkg and tpeg_divider.
module tpeg_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                cmd_avail,
  input  tpeg_pkg::in_item_t  cmd_item,
  output logic                cmd_take,
  output tpeg_pkg::out_item_t res,
  output logic                res_valid,
  input  logic                res_ready
);
  typedef enum logic [1:0] {IDLE, WALK, RISE_STEP, DONE} state_t;
  state_t state;

  logic [63:0] beat_period_q32;
  logic [15:0] pulses_per_beat;
  logic [31:0] trigger_length_us;
  logic [63:0] next_rise_time;
  logic [31:0] rise_fraction;
  logic [15:0] remainder_accumulator;
  logic [63:0] pending_fall_time;
  logic        fall_armed;
  logic        running;
  logic [63:0] pulse_period_q32;
  logic [15:0] pulse_period_remainder;
  logic [31:0] high_time;

  logic [63:0] win_start, win_end;
  logic [tpeg_pkg::LimW-1:0] lim;
  logic [tpeg_pkg::LimW-1:0] n;
  logic [tpeg_pkg::IterW-1:0] iters;
  logic div_start, div_busy, div_pending, reclamp;
  logic [63:0] div_q;
  logic [15:0] div_r;

  // one edge held back so the final one can carry the last flag
  tpeg_pkg::out_item_t hold;
  logic        hold_valid;

  logic        cfg_fire;
  logic        cfg_hit;
  logic        div_done;
  logic        res_free;
  logic        walk_stop;
  logic        in_window;
  logic        res_load;
  logic        fall_first;
  logic [63:0] t;
  logic [31:0] pint;
  logic [16:0] racc;
  logic        carry1;
  logic [32:0] fsum;
  logic [63:0] add;

  tpeg_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(beat_period_q32),
    .divisor(pulses_per_beat), .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  assign cfg_ready = state == IDLE && !div_busy && !div_start && !div_pending;
  assign cmd_take = state == IDLE && cmd_avail && !div_busy && !div_start
                    && !div_pending && !reclamp && !cfg_valid && !res_valid;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_hit = cfg_index != tpeg_pkg::REG_UNUSED;
  assign div_done = div_pending && !div_busy && !div_start;
  assign res_free = !res_valid || res_ready;

  assign fall_first = fall_armed && !tpeg_pkg::s_less(next_rise_time, pending_fall_time);
  assign t = fall_first ? pending_fall_time : next_rise_time;
  assign walk_stop = n >= lim || iters == tpeg_pkg::ITER_CAP || !tpeg_pkg::s_less(t, win_end);
  assign in_window = !tpeg_pkg::s_less(t, win_start);
  assign res_load = res_free && ((state == WALK && !walk_stop && in_window && hold_valid)
                                 || state == DONE);

  assign racc = {1'b0, remainder_accumulator} + {1'b0, pulse_period_remainder};
  assign carry1 = racc >= {1'b0, pulses_per_beat};
  assign add = pulse_period_q32 + 64'(carry1);
  assign fsum = {1'b0, rise_fraction} + {1'b0, add[31:0]};
  assign pint = pulse_period_q32[63:32] < 32'd2 ? 32'd2 : pulse_period_q32[63:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      beat_period_q32 <= 64'd0;
      pulses_per_beat <= 16'd24;
      trigger_length_us <= 32'd5000;
      next_rise_time <= 64'd0;
      rise_fraction <= 32'd0;
      remainder_accumulator <= 16'd0;
      pending_fall_time <= 64'd0;
      fall_armed <= 1'b0;
      running <= 1'b0;
      pulse_period_q32 <= 64'd0;
      pulse_period_remainder <= 16'd0;
      high_time <= 32'd1;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      div_pending <= 1'b0;
      reclamp <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;

      div_start <= cfg_fire && cfg_hit;
      if (cfg_fire && cfg_hit) div_pending <= 1'b1;
      else if (div_done) div_pending <= 1'b0;
      // clamp pulse width in the cycle after the divider result is taken
      reclamp <= div_done;
      if (reclamp) begin
        if ({32'd0, trigger_length_us} >= {32'd0, pint - 32'd1}) high_time <= pint - 32'd1;
        else if (trigger_length_us == 32'd0) high_time <= 32'd1;
        else high_time <= trigger_length_us;
      end
      if (div_done) begin
        if (beat_period_q32 == 64'd0) begin
          pulse_period_q32 <= 64'd0;
          pulse_period_remainder <= 16'd0;
        end else begin
          pulse_period_q32 <= div_q;
          pulse_period_remainder <= div_r;
          if (remainder_accumulator >= pulses_per_beat) remainder_accumulator <= 16'd0;
        end
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          tpeg_pkg::REG_BEAT_PERIOD: beat_period_q32 <= cfg_data;
          tpeg_pkg::REG_PULSES_PER_BEAT:
            pulses_per_beat <= cfg_data[15:0] == 16'd0 ? 16'd1 : cfg_data[15:0];
          tpeg_pkg::REG_TRIGGER_LENGTH: trigger_length_us <= cfg_data[31:0];
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (cmd_take) begin
            if (cmd_item.cmd == tpeg_pkg::CMD_RESTART) begin
              next_rise_time <= cmd_item.origin_time;
              rise_fraction <= 32'd0;
              remainder_accumulator <= 16'd0;
              fall_armed <= 1'b0;
              pending_fall_time <= 64'd0;
              running <= 1'b1;
              state <= DONE;
              n <= '0;
            end else begin
              win_start <= cmd_item.window_start;
              win_end <= cmd_item.window_end;
              lim <= cmd_item.edge_limit > tpeg_pkg::LIM_CAP ? tpeg_pkg::LIM_CAP
                                                             : cmd_item.edge_limit;
              n <= '0;
              iters <= '0;
              state <= (!running || pulse_period_q32 == 64'd0) ? DONE : WALK;
            end
          end
        end
        WALK: begin
          if (res_free) begin
            if (walk_stop) begin
              state <= DONE;
            end else begin
              iters <= iters + tpeg_pkg::ITER_ONE;
              if (in_window) begin
                // release the held edge, hold the new one
                if (hold_valid) res <= hold;
                hold <= '{edge_time: t, rising: !fall_first, edge_valid: 1'b1, last: 1'b0};
                hold_valid <= 1'b1;
                n <= n + tpeg_pkg::LIM_ONE;
              end
              if (fall_first) fall_armed <= 1'b0;
              else begin
                pending_fall_time <= t + {32'd0, high_time};
                fall_armed <= 1'b1;
                state <= RISE_STEP;
              end
            end
          end
        end
        RISE_STEP: begin
          remainder_accumulator <= carry1 ? 16'(racc - {1'b0, pulses_per_beat}) : racc[15:0];
          rise_fraction <= fsum[31:0];
          next_rise_time <= next_rise_time + {32'd0, add[63:32]} + {63'd0, fsum[32]};
          state <= WALK;
        end
        DONE: begin
          if (res_free) begin
            // close with the held edge, or an empty item when nothing was emitted
            if (hold_valid)
              res <= '{edge_time: hold.edge_time, rising: hold.rising, edge_valid: 1'b1,
                       last: 1'b1};
            else
              res <= '{edge_time: 64'd0, rising: 1'b0, edge_valid: 1'b0, last: 1'b1};
            hold_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> src/tempo_pulse_edge_generator_top.sv
// Top level of the tempo pulse edge generator.
// Depends on tpeg_pkg, tpeg_fifo, tpeg_engine.
//
//  channel | handshake           | payload
//  input   | push / full         | in_item  (tpeg_pkg::in_item_t)
//  result  | pop / empty         | out_item (tpeg_pkg::out_item_t)
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A generate command walks at most 4096 edges: a fall edge takes a WALK step,
// a rise edge a WALK step and a RISE_STEP for the period step. The final edge
// of a generate carries the last bit; a generate with no edge returns one empty
// item with last set. A config write holds off further writes while the serial
// divider runs, and commands until the pulse width is settled.
// Reset is synchronous on rst; a result waiting on the output stalls the walk.
module tempo_pulse_edge_generator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tpeg_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output tpeg_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  tpeg_pkg::in_item_t q_item;
  logic q_empty, q_take;
  logic res_valid;

  // front: hold commands while the engine works
  tpeg_fifo u_q (
    .clk(clk), .rst(rst), .push(push), .din(in_item), .full(full),
    .pop(q_take), .dout(q_item), .empty(q_empty)
  );

  tpeg_engine u_eng (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd_avail(!q_empty),
    .cmd_item(q_item), .cmd_take(q_take), .res(out_item),
    .res_valid(res_valid), .res_ready(pop)
  );

  assign empty = !res_valid;
endmodule

>>> tb/tpeg_checker.sv
// Scoreboard for the tempo pulse edge generator: predicts edge items from the
// observed config writes and input items, and compares them with the results.
// Depends on tpeg_pkg.
`timescale 1ns / 1ps

module tpeg_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  tpeg_pkg::in_item_t  in_item,
  input  logic                pop,
  input  logic                empty,
  input  tpeg_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  localparam int EdgeCap = 32;
  localparam int WalkCap = 4096;

  // Register shadows.
  logic [63:0] beat_q32;
  logic [15:0] divider;
  logic [31:0] trig_us;

  // Pulse train state.
  logic [63:0] rise_at;
  logic [31:0] rise_frac;
  int unsigned rem_acc;
  logic [63:0] fall_at;
  logic        fall_armed;
  logic        clock_on;
  logic [63:0] period_q32;
  logic [15:0] period_rem;

  tpeg_pkg::out_item_t edge_queue[$];

  assign pending = edge_queue.size();

  function automatic logic earlier(logic [63:0] a, logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic refresh_period();
    if (beat_q32 == 0) begin
      period_q32 = '0;
      period_rem = '0;
    end else begin
      period_q32 = beat_q32 / divider;
      period_rem = 16'(beat_q32 % divider);
      if (rem_acc >= divider) rem_acc = 0;
    end
  endtask

  task automatic bump_rise();
    logic [63:0] add;
    logic [32:0] sum;
    add = period_q32;
    rem_acc += period_rem;
    if (rem_acc >= divider) begin
      add += 1;
      rem_acc -= divider;
    end
    rem_acc &= 32'hffff;
    sum = {1'b0, rise_frac} + {1'b0, add[31:0]};
    rise_frac = sum[31:0];
    rise_at += {32'd0, add[63:32]} + {63'd0, sum[32]};
  endtask

  function automatic logic [63:0] pulse_high();
    logic [63:0] pint;
    pint = period_q32 >> 32;
    if (pint < 2) pint = 2;
    if ({32'd0, trig_us} >= pint - 1) return pint - 1;
    return (trig_us == 0) ? 64'd1 : {32'd0, trig_us};
  endfunction

  task automatic push_empty();
    tpeg_pkg::out_item_t e;
    e = '0;
    e.last = 1'b1;
    edge_queue.push_back(e);
  endtask

  task automatic predict_edges(tpeg_pkg::in_item_t it);
    int        n;
    int        walked;
    int        lim;
    logic      fall_first;
    logic [63:0] t;
    tpeg_pkg::out_item_t e;
    n = 0;
    walked = 0;
    if (it.cmd == tpeg_pkg::CMD_RESTART) begin
      rise_at = it.origin_time;
      rise_frac = '0;
      rem_acc = 0;
      fall_armed = 1'b0;
      fall_at = '0;
      clock_on = 1'b1;
      push_empty();
      return;
    end
    if (!clock_on || period_q32 == 0) begin
      push_empty();
      return;
    end
    lim = (it.edge_limit > EdgeCap) ? EdgeCap : int'(it.edge_limit);
    while (n < lim && walked < WalkCap) begin
      fall_first = fall_armed && !earlier(rise_at, fall_at);
      t = fall_first ? fall_at : rise_at;
      if (!earlier(t, it.window_end)) break;
      walked++;
      if (!earlier(t, it.window_start)) begin
        e.edge_time = t;
        e.rising = !fall_first;
        e.edge_valid = 1'b1;
        e.last = 1'b0;
        edge_queue.push_back(e);
        n++;
      end
      if (fall_first) begin
        fall_armed = 1'b0;
      end else begin
        fall_at = t + pulse_high();
        fall_armed = 1'b1;
        bump_rise();
      end
    end
    if (n == 0) push_empty();
    else edge_queue[edge_queue.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    tpeg_pkg::out_item_t want;
    if (rst) begin
      beat_q32 = '0;
      divider = 16'd24;
      trig_us = 32'd5000;
      rise_at = '0;
      rise_frac = '0;
      rem_acc = 0;
      fall_at = '0;
      fall_armed = 1'b0;
      clock_on = 1'b0;
      period_q32 = '0;
      period_rem = '0;
      edge_queue.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (edge_queue.size() == 0) begin
          report("unexpected item", out_item.edge_time, 64'd0);
        end else begin
          want = edge_queue.pop_front();
          if (out_item.edge_time !== want.edge_time)
            report("edge_time", out_item.edge_time, want.edge_time);
          if (out_item.rising !== want.rising)
            report("rising", 64'(out_item.rising), 64'(want.rising));
          if (out_item.edge_valid !== want.edge_valid)
            report("edge_valid", 64'(out_item.edge_valid), 64'(want.edge_valid));
          if (out_item.last !== want.last)
            report("last", 64'(out_item.last), 64'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tpeg_pkg::REG_BEAT_PERIOD: beat_q32 = cfg_data;
          tpeg_pkg::REG_PULSES_PER_BEAT:
            divider = (cfg_data[15:0] == 0) ? 16'd1 : cfg_data[15:0];
          tpeg_pkg::REG_TRIGGER_LENGTH: trig_us = cfg_data[31:0];
          default: ;
        endcase
        if (cfg_index != tpeg_pkg::REG_UNUSED) refresh_period();
      end
      if (push && !full) predict_edges(in_item);
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the tempo pulse edge generator testbench: clock, reset, stimulus,
// config writes, watchdog and verdict. Depends on tpeg_pkg, tpeg_checker and
// tempo_pulse_edge_generator_top.
`timescale 1ns / 1ps

module testbench;
  localparam int IdleLimit = 30000;
  localparam int HoldCycles = 600;
  localparam int PhaseItems = 43;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  tpeg_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  tpeg_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [63:0]         cfg_data;
  int                  errors;
  int                  pending;

  // Stimulus bookkeeping: the notional "now" that well-formed windows track.
  logic [63:0] now_us;
  logic [63:0] span_us;
  logic        send_eager;
  int          popped;
  int          idle_cycles;

  tempo_pulse_edge_generator_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tpeg_checker scoreboard (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .pop(pop), .empty(empty), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one item at the falling edge, hold it until the block takes it.
  task automatic send_item(tpeg_pkg::in_item_t it);
    int gap;
    gap = send_eager ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    push = 1'b1;
    in_item = it;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_restart(logic [63:0] origin);
    tpeg_pkg::in_item_t it;
    it = '{cmd: tpeg_pkg::CMD_RESTART, origin_time: origin, window_start: rand64(),
           window_end: rand64(), edge_limit: 6'($urandom)};
    send_item(it);
  endtask

  task automatic send_window(logic [63:0] ws, logic [63:0] we, logic [5:0] lim);
    tpeg_pkg::in_item_t it;
    it = '{cmd: tpeg_pkg::CMD_GENERATE, origin_time: rand64(), window_start: ws,
           window_end: we, edge_limit: lim};
    send_item(it);
  endtask

  // Write one register; only called with the block drained.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_tempo(logic [63:0] beat, logic [15:0] ppb, logic [31:0] trig,
                               logic [63:0] span);
    drain();
    write_reg(tpeg_pkg::REG_BEAT_PERIOD, beat);
    write_reg(tpeg_pkg::REG_PULSES_PER_BEAT, {48'd0, ppb});
    write_reg(tpeg_pkg::REG_TRIGGER_LENGTH, {32'd0, trig});
    span_us = span;
  endtask

  // Mostly well-formed windows marching forward in time; the rest is noise.
  task automatic random_phase();
    logic [63:0] len;
    logic [63:0] origin;
    int          pick;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i % 15 == 0) send_eager = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_restart(now_us);
      end else if (pick < 20) begin
        origin = rand64();
        send_restart(origin);
        now_us = origin;
      end else if (pick < 25) begin
        send_window(rand64(), rand64(), 6'($urandom));
      end else begin
        len = span_us * $urandom_range(0, 3) + (span_us * $urandom_range(0, 7)) / 8;
        send_window(now_us, now_us + len, 6'($urandom_range(0, 40)));
        now_us += len;
      end
    end
  endtask

  // Receiver: random pops, with one long hold-off so the block backs up.
  initial begin
    int  gap;
    logic hold_done;
    pop = 1'b0;
    popped = 0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && popped >= 150) begin
        hold_done = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      gap = ((popped / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
      repeat (gap) @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      popped++;
      @(negedge clk);
      pop = 1'b0;
    end
  end

  // Watchdog: too long with no handshake on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = tpeg_pkg::REG_BEAT_PERIOD;
    cfg_data = '0;
    send_eager = 1'b0;
    now_us = '0;
    span_us = 64'd20833;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: stopped clock, then a 24 ppqn tempo at 120 bpm.
    send_window(64'd0, 64'd100000, 6'd10);
    send_restart(64'd0);
    send_window(64'd0, 64'd100000, 6'd10);
    program_tempo({32'd500000, 32'd0}, 16'd24, 32'd5000, 64'd20834);
    send_restart(64'd0);
    send_window(-64'sd1000, 64'd100000, 6'd0);
    send_window(-64'sd1000, 64'd100000, 6'd63);
    send_window(64'd200000, 64'd150000, 6'd32);
    send_window(64'd300000, 64'd700000, 6'd32);
    send_window(64'd700000, 64'd700000, 6'd5);
    // Time wraps past the largest positive value.
    send_restart(64'h7fff_ffff_ffff_0000);
    send_window(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 6'd32);
    send_window(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 6'd32);
    // Catch-up limit: a window far ahead skips a bounded number of edges.
    send_restart(64'd0);
    send_window(64'h4000_0000_0000_0000, 64'h4000_0000_0001_0000, 6'd32);
    send_window(64'd0, 64'h7fff_ffff_ffff_ffff, 6'd32);
    now_us = '0;
    send_restart(64'd0);
    random_phase();

    // Fast fractional period, minimum pulse width.
    program_tempo({32'd1000, 32'h8000_0001}, 16'd7, 32'd0, 64'd144);
    random_phase();
    // Largest beat, divider written as zero, widest trigger.
    program_tempo(64'hffff_ffff_ffff_ffff, 16'd0, 32'hffff_ffff, 64'h2_0000_0000);
    random_phase();
    // Sub-microsecond period with the largest divider.
    program_tempo({32'd100, 32'h1234_5678}, 16'hffff, 32'd3, 64'd3);
    random_phase();
    // Zero beat stops output.
    program_tempo(64'd0, 16'd24, 32'd5000, 64'd20000);
    random_phase();
    program_tempo({12'd0, 20'($urandom), $urandom}, 16'($urandom_range(1, 100)),
                  $urandom_range(0, 2000), 64'd4000);
    random_phase();

    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
